// File: design/quaternion_to_euler_angles_top_macros.svh
// Assertion macros for the quaternion to Euler angle block.
// Used by the port checker; depends on clk and arst_n being in scope.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH

// Plain property check, disabled during reset.
`define QTE_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("qte assertion failed");

// A signal holds its value in the cycle after a condition.
`define QTE_ASSERT_HOLD(name, cond, sig) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error("qte hold assertion failed");

`endif

// File: design/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle block.
// No dependencies; used by the cells and the top level.
package qte_pkg;

	localparam int XW       = 37;  // CORDIC vector width, Q.28 with headroom
	localparam int ZW       = 28;  // angle accumulator width, Q.24
	localparam int SW       = 30;  // clamped pitch term width
	localparam int SQ_W     = 58;  // square root remainder and root width
	localparam int SQ_STEPS = 29;  // one root bit per cell
	localparam int ATAN_LEN = 24;

	localparam logic signed [XW-1:0] ONE_Q28 = XW'(64'sd268435456);
	localparam logic signed [ZW-1:0] PI_Q24  = 28'sd52707179;
	localparam logic signed [17:0]   ANGLE_MAX = 18'sd25736;
	localparam logic signed [17:0]   PITCH_MAX = 18'sd12868;

	localparam logic signed [ZW-1:0] ATAN_Q24 [ATAN_LEN] = '{
		28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
		28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
		28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
		28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
		28'sd256,      28'sd128,     28'sd64,      28'sd32,
		28'sd16,       28'sd8,       28'sd4,       28'sd2
	};

	typedef struct packed {
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_vec_t;

	typedef struct packed {
		logic [SQ_W-1:0] n;
		logic [SQ_W-1:0] r;
	} sq_t;

	typedef struct packed {
		logic signed [XW-1:0] roll_n;
		logic signed [XW-1:0] roll_d;
		logic signed [XW-1:0] yaw_n;
		logic signed [XW-1:0] yaw_d;
		logic signed [SW-1:0] s;
	} terms_t;

	// Q.24 angle to Q.13, rounding half up, then saturating to +/- lim.
	function automatic logic signed [17:0] round_sat(input logic signed [ZW-1:0] a,
			input logic signed [17:0] lim);
		logic signed [ZW:0]  sum;
		logic signed [17:0]  r;
		sum = (ZW+1)'(a) + (ZW+1)'(1024);
		r   = 18'(sum >>> 11);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

endpackage

// File: design/qte_isqrt_cell.sv
// One cell of the pipelined integer square root: settles one root bit.
// Depends on qte_pkg.
module qte_isqrt_cell #(
	parameter int K = 0
) (
	input  logic         clk,
	input  logic         en,
	input  qte_pkg::sq_t sin,
	output qte_pkg::sq_t sout
);
	import qte_pkg::*;

	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

	logic [SQ_W-1:0] trial;
	sq_t             nxt;

	always_comb begin
		trial = sin.r + BIT;
		if (sin.n >= trial) begin
			nxt.n = sin.n - trial;
			nxt.r = (sin.r >> 1) + BIT;
		end else begin
			nxt.n = sin.n;
			nxt.r = sin.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			sout <= nxt;
	end

endmodule

// File: design/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation with a fixed shift.
// Depends on qte_pkg.
module qte_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  qte_pkg::cordic_vec_t vin,
	output qte_pkg::cordic_vec_t vout
);
	import qte_pkg::*;

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	cordic_vec_t          nxt;

	always_comb begin
		xs  = vin.x >>> STEP;
		ys  = vin.y >>> STEP;
		nxt = vin;
		// Rotate toward the x axis; the sign of y picks the direction.
		if (!vin.y[XW-1]) begin
			nxt.x = vin.x + ys;
			nxt.y = vin.y - xs;
			nxt.z = vin.z + ATAN_Q24[STEP];
		end else begin
			nxt.x = vin.x - ys;
			nxt.y = vin.y + xs;
			nxt.z = vin.z - ATAN_Q24[STEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			vout <= nxt;
	end

endmodule

// File: design/quaternion_to_euler_angles_top.sv
// Channel   Handshake            Words
// input     in_valid/in_ready    quat_w, quat_x, quat_y, quat_z (Q1.14)
// output    out_valid/out_ready  roll_angle, yaw_angle (Q2.13), pitch_angle (Q1.13)
//
// One word is accepted per clock whenever the pipeline advances; the stages are
// products, sums, square, 29 root cells, quadrant turn, CORDIC cells, rounding.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears only the valid bits; the data registers are not reset.
// Depends on qte_pkg, qte_isqrt_cell and qte_cordic_cell.
module quaternion_to_euler_angles_top #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle
);
	import qte_pkg::*;

	localparam int NIT = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
	localparam int LAT = 3 + SQ_STEPS + 1 + NIT;

	logic           en;
	logic [LAT-1:0] vld_q;
	logic           out_valid_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], in_valid};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// Stage 1: all products.
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, wy_s1, zx_s1, zz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			wy_s1 <= quat_w * quat_y;
			zx_s1 <= quat_z * quat_x;
			zz_s1 <= quat_z * quat_z;
		end
	end

	// Stage 2: product sums and the clamped pitch term.
	terms_t               t_s2;
	terms_t               t_nxt;
	logic signed [XW-1:0] s_full;

	always_comb begin
		t_nxt.roll_n = XW'(wx_s1) + XW'(yz_s1);
		t_nxt.roll_n = t_nxt.roll_n <<< 1;
		t_nxt.roll_d = ONE_Q28 - ((XW'(xx_s1) + XW'(yy_s1)) <<< 1);
		t_nxt.yaw_n  = (XW'(wz_s1) + XW'(xy_s1)) <<< 1;
		t_nxt.yaw_d  = ONE_Q28 - ((XW'(yy_s1) + XW'(zz_s1)) <<< 1);
		s_full       = (XW'(wy_s1) - XW'(zx_s1)) <<< 1;
		if (s_full > ONE_Q28)
			s_full = ONE_Q28;
		if (s_full < -ONE_Q28)
			s_full = -ONE_Q28;
		t_nxt.s = SW'(s_full);
	end

	always_ff @(posedge clk) begin
		if (en)
			t_s2 <= t_nxt;
	end

	// Stage 3: square of the pitch term.
	terms_t             t_s3;
	logic [56:0]        ss_s3;
	logic signed [59:0] ss_full;

	assign ss_full = t_s2.s * t_s2.s;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3  <= t_s2;
			ss_s3 <= ss_full[56:0];
		end
	end

	// Root chain: floor sqrt of 2^56 - s^2, with the other terms riding alongside.
	sq_t    sq_in;
	sq_t    sq_q   [SQ_STEPS];
	terms_t tdly_q [SQ_STEPS];

	always_comb begin
		sq_in.n = (SQ_W'(1) << 56) - SQ_W'(ss_s3);
		sq_in.r = '0;
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
		if (j == 0) begin : g_first
			qte_isqrt_cell #(.K(SQ_STEPS - 1)) u_cell (
				.clk(clk), .en(en), .sin(sq_in), .sout(sq_q[0])
			);
			always_ff @(posedge clk) begin
				if (en)
					tdly_q[0] <= t_s3;
			end
		end else begin : g_next
			qte_isqrt_cell #(.K(SQ_STEPS - 1 - j)) u_cell (
				.clk(clk), .en(en), .sin(sq_q[j-1]), .sout(sq_q[j])
			);
			always_ff @(posedge clk) begin
				if (en)
					tdly_q[j] <= tdly_q[j-1];
			end
		end
	end

	// Quadrant turn: a vector in the left half plane is turned by pi first.
	cordic_vec_t pre_in   [3];
	cordic_vec_t pre_turn [3];
	cordic_vec_t pre_q    [3];
	terms_t      tl;

	always_comb begin
		tl          = tdly_q[SQ_STEPS-1];
		pre_in[0].x = tl.roll_d;
		pre_in[0].y = tl.roll_n;
		pre_in[1].x = XW'(sq_q[SQ_STEPS-1].r);
		pre_in[1].y = XW'(tl.s);
		pre_in[2].x = tl.yaw_d;
		pre_in[2].y = tl.yaw_n;
		for (int c = 0; c < 3; c++) begin
			pre_in[c].zero = (pre_in[c].x == '0) && (pre_in[c].y == '0);
			pre_in[c].z    = '0;
			pre_turn[c]    = pre_in[c];
			if (pre_in[c].x[XW-1]) begin
				pre_turn[c].x = -pre_in[c].x;
				pre_turn[c].y = -pre_in[c].y;
				pre_turn[c].z = pre_in[c].y[XW-1] ? -PI_Q24 : PI_Q24;
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_pre
		always_ff @(posedge clk) begin
			if (en)
				pre_q[c] <= pre_turn[c];
		end
	end

	// CORDIC cell rows, one per angle.
	cordic_vec_t vec [3][NIT];

	for (genvar c = 0; c < 3; c++) begin : g_ch
		for (genvar i = 0; i < NIT; i++) begin : g_it
			if (i == 0) begin : g_first
				qte_cordic_cell #(.STEP(0)) u_cell (
					.clk(clk), .en(en), .vin(pre_q[c]), .vout(vec[c][0])
				);
			end else begin : g_next
				qte_cordic_cell #(.STEP(i)) u_cell (
					.clk(clk), .en(en), .vin(vec[c][i-1]), .vout(vec[c][i])
				);
			end
		end
	end

	// Output register: round to Q2.13 (pitch to Q1.13) and saturate.
	logic signed [ZW-1:0] ang [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			ang[c] = vec[c][NIT-1].zero ? '0 : vec[c][NIT-1].z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_angle  <= 16'(round_sat(ang[0], ANGLE_MAX));
			pitch_angle <= 15'(round_sat(ang[1], PITCH_MAX));
			yaw_angle   <= 16'(round_sat(ang[2], ANGLE_MAX));
		end
	end

endmodule

// File: design/qte_checker.sv
// Port-level checks for the quaternion to Euler angle block, bound to the top.
// Depends on quaternion_to_euler_angles_top_macros.svh.
`include "quaternion_to_euler_angles_top_macros.svh"

module qte_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [15:0] quat_w,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] roll_angle,
	input logic signed [14:0] pitch_angle,
	input logic signed [15:0] yaw_angle
);

	// An empty output register never holds off the input.
	`QTE_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)
	// A stalled output word keeps its valid.
	`QTE_ASSERT(a_out_valid_holds, (out_valid && !out_ready) |=> out_valid)
	`QTE_ASSERT_HOLD(a_pitch_holds, out_valid && !out_ready, pitch_angle)
	// Delivered angles stay inside their saturation limits.
	`QTE_ASSERT(a_pitch_range, out_valid |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
	`QTE_ASSERT(a_roll_yaw_range, out_valid |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736 && yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736))

endmodule

bind quaternion_to_euler_angles_top qte_checker u_qte_checker (.*);
